// File: hdl/piecewise_linear_l2_norm_unit_assert.svh
// ----------------------------------------------------------------------------
// piecewise_linear_l2_norm_unit_assert.svh
// Assertion macros shared by the curve norm RTL. Every check is sampled on the
// rising clock edge and is switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_L2_NORM_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_L2_NORM_UNIT_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PLL2N_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define PLL2N_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hdl/pll2n_pkg.sv
// ----------------------------------------------------------------------------
// pll2n_pkg
// Types and fixed constants of the piecewise linear curve L2 norm unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pll2n_pkg;

   // Coordinate format: signed fixed point with COORD_FRAC_BITS fraction bits
   localparam int COORD_WIDTH     = 16;
   localparam int COORD_FRAC_BITS = 8;

   // Segment arithmetic widths
   localparam int DX_WIDTH    = COORD_WIDTH + 1;          // x difference
   localparam int SUMSQ_WIDTH = 2 * COORD_WIDTH + 1;      // y1*y1 + y1*y2 + y2*y2
   localparam int PROD_WIDTH  = DX_WIDTH + SUMSQ_WIDTH;   // multiplier result
   localparam int ACC_WIDTH   = 64;                       // integral accumulator
   localparam int NORM_WIDTH  = 31;

   // Scale from three times the integral (raw units) to the Q.24 square
   localparam int NORM_SHIFT = 24 - 3 * COORD_FRAC_BITS;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic                          last_point;
   } point_req_type;

   typedef struct packed {
      logic [NORM_WIDTH-1:0] norm;
      logic                  negative_sum;
      logic                  overflowed;
   } norm_rsp_type;

   // Status of the square root engine seen by the sequencer
   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic                  negative;
      logic [NORM_WIDTH-1:0] root;
   } root_stat_type;

endpackage

`default_nettype wire

// File: hdl/pll2n_mul.sv
// ----------------------------------------------------------------------------
// pll2n_mul
// Shared signed multiplier with a registered product. Every segment product
// of the unit passes through this one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pll2n_mul
   import pll2n_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic signed [DX_WIDTH-1:0]    mul_a,
   input  wire logic signed [SUMSQ_WIDTH-1:0] mul_b,
   output      logic signed [PROD_WIDTH-1:0]  mul_p
);

   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;

   // Full-width signed product, registered every cycle
   always_comb begin
      prod_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

// File: hdl/pll2n_root.sv
// ----------------------------------------------------------------------------
// pll2n_root
// Iterative norm engine: divides the accumulated sum by three with a short
// shift-and-add series and a remainder fix-up, scales it to Q.24 and takes
// the integer square root two bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pll2n_root
   import pll2n_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [ACC_WIDTH-1:0] value,
   output      root_stat_type               stat
);

   localparam int ShiftLeft  = (NORM_SHIFT > 0) ? NORM_SHIFT : 0;
   localparam int ShiftRight = (NORM_SHIFT < 0) ? -NORM_SHIFT : 0;

   localparam logic [2:0] R_IDLE  = 3'd0;
   localparam logic [2:0] R_DIV   = 3'd1;
   localparam logic [2:0] R_REM   = 3'd2;
   localparam logic [2:0] R_FIX   = 3'd3;
   localparam logic [2:0] R_SCALE = 3'd4;
   localparam logic [2:0] R_SQRT  = 3'd5;
   localparam logic [2:0] R_DONE  = 3'd6;

   localparam logic [ACC_WIDTH-1:0] FirstBit = ACC_WIDTH'(1) << (ACC_WIDTH - 2);

   logic [2:0]            state_ff, state_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [ACC_WIDTH-1:0]  work_ff, work_in;
   logic [ACC_WIDTH-1:0]  res_ff, res_in;
   logic [ACC_WIDTH-1:0]  bit_ff, bit_in;
   logic                  neg_ff, neg_in;
   logic [NORM_WIDTH-1:0] root_ff, root_in;

   logic [ACC_WIDTH-1:0] div_seed;
   logic [ACC_WIDTH-1:0] div_step;
   logic [ACC_WIDTH-1:0] div_rem;
   logic                 fix_ge;
   logic [ACC_WIDTH-1:0] scaled;
   logic [ACC_WIDTH-1:0] trial;
   logic [ACC_WIDTH-1:0] res_next;
   logic                 take;

   // Division by three: the series n/4 + n/16 + ... never overshoots, so a
   // few compare and subtract steps on the remainder finish the quotient
   always_comb begin
      div_seed = (unsigned'(value) >> 2) + (unsigned'(value) >> 4);
      div_step = res_ff + (res_ff >> (6'd4 << cnt_ff[1:0]));
      div_rem  = work_ff - (res_ff + (res_ff << 1));
      fix_ge   = (work_ff >= ACC_WIDTH'(3));
   end

   // Scale the quotient: left shifts saturate, right shifts truncate
   always_comb begin
      if ((work_ff >> (ACC_WIDTH - ShiftLeft)) != '0) begin
         scaled = '1;
      end else begin
         scaled = work_ff << ShiftLeft;
      end
      scaled = scaled >> ShiftRight;
   end

   // One square root step
   always_comb begin
      trial = res_ff + bit_ff;
      take  = (work_ff >= trial);
      if (take) begin
         res_next = (res_ff >> 1) + bit_ff;
      end else begin
         res_next = res_ff >> 1;
      end
   end

   // Sequence the division, scale and root phases
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      work_in  = work_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      neg_in   = neg_ff;
      root_in  = root_ff;
      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               if (value[ACC_WIDTH-1]) begin
                  neg_in   = 1'b1;
                  root_in  = '0;
                  state_in = R_DONE;
               end else begin
                  neg_in   = 1'b0;
                  work_in  = ACC_WIDTH'(unsigned'(value));
                  res_in   = div_seed;
                  cnt_in   = '0;
                  state_in = R_DIV;
               end
            end
         end
         R_DIV: begin
            res_in = div_step;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = R_REM;
            end
         end
         R_REM: begin
            work_in  = div_rem;
            state_in = R_FIX;
         end
         R_FIX: begin
            if (fix_ge) begin
               work_in = work_ff - ACC_WIDTH'(3);
               res_in  = res_ff + ACC_WIDTH'(1);
            end else begin
               work_in  = res_ff;
               state_in = R_SCALE;
            end
         end
         R_SCALE: begin
            work_in  = scaled;
            res_in   = '0;
            bit_in   = FirstBit;
            cnt_in   = 6'(ACC_WIDTH / 2 - 1);
            state_in = R_SQRT;
         end
         R_SQRT: begin
            if (take) begin
               work_in = work_ff - trial;
            end
            res_in = res_next;
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               if (res_next[ACC_WIDTH-1:NORM_WIDTH] != '0) begin
                  root_in = '1;
               end else begin
                  root_in = res_next[NORM_WIDTH-1:0];
               end
               state_in = R_DONE;
            end
         end
         R_DONE: begin
            state_in = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      neg_ff  <= neg_in;
      root_ff <= root_in;
   end

   always_comb begin
      stat.busy     = (state_ff != R_IDLE);
      stat.done     = (state_ff == R_DONE);
      stat.negative = neg_ff;
      stat.root     = root_ff;
   end

endmodule

`default_nettype wire

// File: hdl/piecewise_linear_l2_norm_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_l2_norm_unit
// L2 norm of a piecewise linear curve fed one point per transaction. Each
// segment adds dx*(y1*y1 + y1*y2 + y2*y2) to a saturating accumulator; the
// last point of a curve returns the square root of the integral in Q.12.
// ----------------------------------------------------------------------------
//  channel  | direction | payload          | handshake
//  req_     | in        | point_req_type   | req_valid / req_ready
//  rsp_     | out       | norm_rsp_type    | rsp_valid / rsp_ready
//
//  A point that opens no segment needs no multiplier pass; a segment point
//  takes three passes through the shared multiplier and the add.
//  A last point adds four shift-add division steps, a short remainder
//  fix-up and 32 square root steps in the norm engine, plus any wait on
//  rsp_ready. req_ready is low while busy.
//  Synchronous reset clears the sequencer, the previous point and the sum.
//  A result waiting on rsp_ does not block points that produce no result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "piecewise_linear_l2_norm_unit_assert.svh"

module piecewise_linear_l2_norm_unit
   import pll2n_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire point_req_type req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      norm_rsp_type  rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SQ2   = 3'd1;
   localparam logic [2:0] ST_SUMSQ = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_ACC   = 3'd4;
   localparam logic [2:0] ST_START = 3'd5;
   localparam logic [2:0] ST_ROOT  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   logic [2:0]                    state_ff, state_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_WIDTH-1:0] prev_y_ff, prev_y_in;
   logic                          have_prev_ff, have_prev_in;
   logic                          last_ff, last_in;
   logic signed [DX_WIDTH-1:0]    dx_ff, dx_in;
   logic signed [SUMSQ_WIDTH-1:0] sumsq_ff, sumsq_in;
   logic signed [ACC_WIDTH-1:0]   sum_ff, sum_in;
   logic                          sat_ff, sat_in;
   logic                          ovf_hold_ff, ovf_hold_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   norm_rsp_type                  rsp_data_ff, rsp_data_in;

   logic                          req_take;
   logic                          rsp_free;
   logic signed [DX_WIDTH-1:0]    mul_a;
   logic signed [SUMSQ_WIDTH-1:0] mul_b;
   logic signed [PROD_WIDTH-1:0]  mul_p;
   logic signed [SUMSQ_WIDTH-1:0] mul_low;
   logic signed [ACC_WIDTH:0]     acc_wide;
   logic                          acc_ovf;
   logic signed [ACC_WIDTH-1:0]   acc_sat;
   logic                          root_start;
   root_stat_type                 root_stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign mul_low   = mul_p[SUMSQ_WIDTH-1:0];

   // Route operands to the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_SQ2: begin
            mul_a = DX_WIDTH'(prev_y_ff);
            mul_b = SUMSQ_WIDTH'(prev_y_ff);
         end
         ST_SCALE: begin
            mul_a = dx_ff;
            mul_b = sumsq_ff;
         end
         default: begin
            mul_a = DX_WIDTH'(prev_y_ff);
            mul_b = SUMSQ_WIDTH'(DX_WIDTH'(prev_y_ff) + DX_WIDTH'(req_data.point_y));
         end
      endcase
   end

   pll2n_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // Saturating accumulate of the segment product
   always_comb begin
      acc_wide = (ACC_WIDTH+1)'(sum_ff) + (ACC_WIDTH+1)'(mul_p);
      acc_ovf  = (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1]);
      if (acc_ovf) begin
         acc_sat = acc_wide[ACC_WIDTH] ? AccMin : AccMax;
      end else begin
         acc_sat = acc_wide[ACC_WIDTH-1:0];
      end
   end

   assign root_start = (state_ff == ST_START);

   pll2n_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (sum_ff),
      .stat  (root_stat)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      last_in      = last_ff;
      dx_in        = dx_ff;
      sumsq_in     = sumsq_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      ovf_hold_in  = ovf_hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               dx_in        = DX_WIDTH'(req_data.point_x) - DX_WIDTH'(prev_x_ff);
               prev_x_in    = req_data.point_x;
               prev_y_in    = req_data.point_y;
               have_prev_in = !req_data.last_point;
               last_in      = req_data.last_point;
               if (have_prev_ff && (req_data.point_x != prev_x_ff)) begin
                  state_in = ST_SQ2;
               end else if (req_data.last_point) begin
                  state_in = ST_START;
               end
            end
         end
         ST_SQ2: begin
            sumsq_in = mul_low;
            state_in = ST_SUMSQ;
         end
         ST_SUMSQ: begin
            sumsq_in = sumsq_ff + mul_low;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in   = acc_sat;
            sat_in   = sat_ff || acc_ovf;
            state_in = last_ff ? ST_START : ST_IDLE;
         end
         ST_START: begin
            // hand the sum to the norm engine and open a fresh curve
            ovf_hold_in = sat_ff;
            sum_in      = '0;
            sat_in      = 1'b0;
            state_in    = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_data_in.norm         = root_stat.negative ? '0 : root_stat.root;
               rsp_data_in.negative_sum = root_stat.negative;
               rsp_data_in.overflowed   = ovf_hold_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      dx_ff       <= dx_in;
      sumsq_ff    <= sumsq_in;
      ovf_hold_ff <= ovf_hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `PLL2N_ASSERT_IMPLY(a_neg_zero_norm, rsp_valid && rsp_data.negative_sum, rsp_data.norm == '0)
   `PLL2N_ASSERT_NEXT(a_last_busy, req_take && req_data.last_point, !req_ready)
   `PLL2N_ASSERT_IMPLY(a_done_in_root, root_stat.done, state_ff == ST_ROOT)

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the curve L2 norm unit. Drive curves as point
// transactions: a typed stimulus table first, then random curves. Compare
// every norm transaction field by field against its typed table row or else
// an in-bench integral predictor, under random idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import pll2n_pkg::*;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam int CYCLE_LIMIT = 500_000;
   localparam int DRAIN_WAIT  = 150;

   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [63:0] NORM_CAP = 64'h7FFF_FFFF;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic                          last;
      logic                          typed;
      logic [NORM_WIDTH-1:0]         norm;
      logic                          neg;
      logic                          ovf;
   } plan_row_type;

   localparam int PLAN_ROWS = 23;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   point_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   norm_rsp_type  rsp_data;

   norm_rsp_type pending_norms[$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           stall_left  = 0;
   bit           quiet       = 1'b0;

   // Predictor copy of the curve state
   logic signed [COORD_WIDTH-1:0] held_x       = '0;
   logic signed [COORD_WIDTH-1:0] held_y       = '0;
   bit                            held_valid   = 1'b0;
   longint                        area_sum     = 0;
   bit                            area_clipped = 1'b0;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      // single point right after reset
      '{0, 0, 1'b1, 1'b1, 0, 1'b0, 1'b0},
      // single points at the coordinate extremes
      '{COORD_MIN, COORD_MAX, 1'b1, 1'b1, 0, 1'b0, 1'b0},
      '{COORD_MAX, COORD_MIN, 1'b1, 1'b1, 0, 1'b0, 1'b0},
      // height 1.0 over [0, 1]: norm 1.0 in Q.12
      '{0, 256, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{256, 256, 1'b1, 1'b1, 4096, 1'b0, 1'b0},
      // height -1.0 over [0, 1]: same norm
      '{0, -256, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{256, -256, 1'b1, 1'b1, 4096, 1'b0, 1'b0},
      // decreasing x gives a negative integral
      '{256, 256, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{0, 256, 1'b1, 1'b1, 0, 1'b1, 1'b0},
      // equal x values add nothing
      '{100, 500, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{100, -700, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{100, COORD_MAX, 1'b1, 1'b1, 0, 1'b0, 1'b0},
      // full-width segment at the most negative height
      '{COORD_MIN, COORD_MIN, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{COORD_MAX, COORD_MIN, 1'b1, 1'b0, 0, 1'b0, 1'b0},
      // full width at the top, down a vertical edge, back at mixed height
      '{COORD_MIN, COORD_MAX, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{COORD_MAX, COORD_MAX, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{COORD_MAX, COORD_MIN, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{COORD_MIN, 0, 1'b1, 1'b0, 0, 1'b0, 1'b0},
      // alternating bit patterns
      '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{16'hAAAA, 16'h5555, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{16'h7FFF, 16'h0001, 1'b1, 1'b0, 0, 1'b0, 1'b0},
      // flat zero curve
      '{-100, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0},
      '{300, 0, 1'b1, 1'b1, 0, 1'b0, 1'b0}
   };

   piecewise_linear_l2_norm_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Generate the clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Advance the curve state by one point; return 1 when a norm comes out
   function automatic bit accumulate_point(input point_req_type p,
                                           output norm_rsp_type r);
      longint      new_x;
      longint      new_y;
      longint      old_y;
      longint      term;
      logic [63:0] q;
      logic [63:0] root;
      logic [63:0] trial;
      r     = '0;
      new_x = longint'($signed(p.point_x));
      new_y = longint'($signed(p.point_y));
      old_y = longint'($signed(held_y));
      if (held_valid && p.point_x != held_x) begin
         term = (new_x - longint'($signed(held_x))) *
                (old_y * old_y + old_y * new_y + new_y * new_y);
         if (term > 0 && area_sum > SUM_MAX - term) begin
            area_sum     = SUM_MAX;
            area_clipped = 1'b1;
         end else if (term < 0 && area_sum < SUM_MIN - term) begin
            area_sum     = SUM_MIN;
            area_clipped = 1'b1;
         end else begin
            area_sum = area_sum + term;
         end
      end
      held_x     = p.point_x;
      held_y     = p.point_y;
      held_valid = 1'b1;
      if (!p.last_point)
         return 1'b0;

      // Scale three times the integral to Q.24, then take the floor root
      if (area_sum < 0) begin
         r.negative_sum = 1'b1;
      end else begin
         q = area_sum;
         q = q / 64'd3;
         if (NORM_SHIFT > 0) begin
            if (q > ({64{1'b1}} >> NORM_SHIFT))
               q = '1;
            else
               q = q << NORM_SHIFT;
         end else begin
            q = q >> (-NORM_SHIFT);
         end
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= q)
               root = trial;
         end
         if (root > NORM_CAP)
            root = NORM_CAP;
         r.norm = root[NORM_WIDTH-1:0];
      end
      r.overflowed = area_clipped;

      // Clear the curve for the next one
      held_valid   = 1'b0;
      area_sum     = 0;
      area_clipped = 1'b0;
      return 1'b1;
   endfunction

   // Random coordinate: full range, near zero, or an extreme
   function automatic logic signed [COORD_WIDTH-1:0] pick_coord(input int mode);
      case (mode)
         0: return COORD_WIDTH'($urandom);
         1: return COORD_WIDTH'($urandom_range(0, 1023) - 512);
         default: begin
            case ($urandom_range(0, 4))
               0: return COORD_MIN;
               1: return -1;
               2: return 0;
               3: return 1;
               default: return COORD_MAX;
            endcase
         end
      endcase
   endfunction

   // Offer one point transaction and record its norm when it closes a curve
   task automatic offer_point(input point_req_type p, input bit use_typed,
                              input norm_rsp_type typed_norm);
      int           gap;
      norm_rsp_type predicted;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 5);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      if (accumulate_point(p, predicted))
         pending_norms.push_back(use_typed ? typed_norm : predicted);
   endtask

   // Hold the sender idle until every norm has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_norms.size() != 0)
         @(negedge clock);
   endtask

   // Random curves of mostly short length with varied x progressions
   task automatic run_curves(input int point_budget);
      int            sent;
      int            length;
      int            x_mode;
      int            y_mode;
      int            xw;
      point_req_type pt;
      sent = 0;
      while (sent < point_budget) begin
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30)
                                              : $urandom_range(1, 6);
         x_mode = $urandom_range(0, 3);
         y_mode = $urandom_range(0, 2);
         xw     = int'(pick_coord($urandom_range(0, 2)));
         for (int k = 0; k < length; k++) begin
            case (x_mode)
               0: begin
                  if (k > 0)
                     xw = xw + int'($urandom_range(0, 400));
                  if (xw > int'(COORD_MAX))
                     xw = int'(COORD_MAX);
               end
               1: begin
                  if (k > 0)
                     xw = xw - int'($urandom_range(0, 400));
                  if (xw < int'(COORD_MIN))
                     xw = int'(COORD_MIN);
               end
               2: xw = int'(pick_coord(0));
               default: xw = int'(pick_coord(2));
            endcase
            pt.point_x    = xw[COORD_WIDTH-1:0];
            pt.point_y    = pick_coord(y_mode);
            pt.last_point = (k == length - 1);
            offer_point(pt, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // Stall the result channel in random bursts while the bench is not quiet
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check each norm transaction against the oldest expectation
   always @(posedge clock) begin
      norm_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_norms.size() == 0) begin
            $display("%0t: unexpected norm transaction, expected none, actual %p",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = pending_norms.pop_front();
            if (rsp_data.norm !== want.norm) begin
               $display("%0t: norm mismatch, expected %0d, actual %0d",
                        $time, want.norm, rsp_data.norm);
               error_count++;
            end
            if (rsp_data.negative_sum !== want.negative_sum) begin
               $display("%0t: negative_sum mismatch, expected %0b, actual %0b",
                        $time, want.negative_sum, rsp_data.negative_sum);
               error_count++;
            end
            if (rsp_data.overflowed !== want.overflowed) begin
               $display("%0t: overflowed mismatch, expected %0b, actual %0b",
                        $time, want.overflowed, rsp_data.overflowed);
               error_count++;
            end
         end
      end
   end

   // End the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Main sequence
   initial begin
      point_req_type pt;
      norm_rsp_type  typed;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_plan[i]) begin
         pt    = '{directed_plan[i].x, directed_plan[i].y, directed_plan[i].last};
         typed = '{directed_plan[i].norm, directed_plan[i].neg, directed_plan[i].ovf};
         offer_point(pt, directed_plan[i].typed, typed);
      end
      wait_for_results();

      // Random curves with idling, a full drain, then a stretch without idling
      run_curves(900);
      wait_for_results();
      quiet = 1'b1;
      run_curves(150);

      wait_for_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && pending_norms.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/pll2n_pkg.sv
hdl/pll2n_mul.sv
hdl/pll2n_root.sv
hdl/piecewise_linear_l2_norm_unit.sv
sim/tb_top.sv
